### rtl/core/sha512_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 package
// Word types, round constants and the SHA-512 mixing functions.
// ----------------------------------------------------------------------------
package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  localparam logic [3:0] MaxBytes  = 4'd8;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [3:0] LenWord   = 4'd14;
  localparam logic [63:0] PadByte  = 64'h8000_0000_0000_0000;

  localparam logic [63:0] InitH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

### rtl/core/sha512_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 front end
// Accepts message words, saturates the byte count and queues them.
// ----------------------------------------------------------------------------
module sha512_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  sha512_pkg::in_item_t item,
  output logic                 full,
  output logic                 q_valid,
  output sha512_pkg::in_item_t q_item,
  input  wire                  q_take
);
  import sha512_pkg::*;

  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  in_item_t   clean;
  logic       do_push;
  logic       do_take;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_take = q_take && q_valid;

  always_comb begin
    clean = item;
    if (item.byte_count > MaxBytes) begin
      clean.byte_count = MaxBytes;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= clean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

endmodule
`default_nettype wire

### rtl/core/sha512_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 back end
// Packs bytes into blocks, pads, runs the rounds and emits the digest.
// ----------------------------------------------------------------------------
module sha512_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  input  sha512_pkg::in_item_t  q_item,
  output logic                  q_take,
  output logic                  empty,
  output sha512_pkg::out_item_t result,
  input  wire                   pop
);
  import sha512_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD80 = 7'b0000010,
    S_PADZ  = 7'b0000100,
    S_PADL  = 7'b0001000,
    S_COMP  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t      state;
  state_t      state_next;
  state_t      ret;
  state_t      after;
  logic [63:0] win [16];
  logic [63:0] hash [8];
  logic [63:0] v [8];
  logic [63:0] acc;
  logic [6:0]  fill;
  logic [63:0] bit_length;
  logic [6:0]  rnd;
  logic [2:0]  eidx;

  logic         feed;
  logic [63:0]  feed_data;
  logic [3:0]   feed_cnt;
  logic [63:0]  masked;
  logic [127:0] combined;
  logic [3:0]   tot;
  logic         push_word;
  logic         blk_done;
  logic [63:0]  t1;
  logic [63:0]  t2;
  logic [63:0]  w_new;
  logic         emit_take;

  always_comb begin
    feed      = 1'b0;
    feed_data = 64'd0;
    feed_cnt  = 4'd0;
    after     = state;
    q_take    = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          feed      = 1'b1;
          feed_data = q_item.data_word;
          feed_cnt  = q_item.byte_count;
          after     = q_item.last_word ? S_PAD80 : S_IDLE;
        end
      end
      S_PAD80: begin
        feed      = 1'b1;
        feed_data = PadByte;
        feed_cnt  = 4'd1;
        after     = S_PADZ;
      end
      S_PADZ: begin
        feed = 1'b1;
        if (fill[2:0] != 3'd0) begin
          feed_cnt = MaxBytes - {1'b0, fill[2:0]};
        end else begin
          feed_cnt = MaxBytes;
          if (fill[6:3] == LenWord) begin
            after = S_PADL;
          end
        end
      end
      S_PADL: begin
        feed      = 1'b1;
        feed_data = bit_length;
        feed_cnt  = MaxBytes;
        after     = S_EMIT;
      end
      default: begin
      end
    endcase
  end

  assign masked    = feed_data & ~({64{1'b1}} >> {feed_cnt, 3'b000});
  assign combined  = {(fill[2:0] == 3'd0) ? 64'd0 : acc, 64'd0}
                   | ({masked, 64'd0} >> {fill[2:0], 3'b000});
  assign tot       = {1'b0, fill[2:0]} + feed_cnt;
  assign push_word = feed && tot[3];
  assign blk_done  = push_word && (fill[6:3] == 4'd15);

  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + win[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];

  assign empty     = (state != S_EMIT);
  assign emit_take = pop && !empty;
  assign result.digest_word  = hash[eidx];
  assign result.digest_index = eidx;
  assign result.digest_last  = (eidx == 3'd7);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_PAD80, S_PADZ, S_PADL: begin
        if (blk_done) begin
          state_next = S_COMP;
        end else begin
          state_next = after;
        end
      end
      S_COMP: begin
        if (rnd == LastRound) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = ret;
      end
      S_EMIT: begin
        if (emit_take && eidx == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      fill       <= 7'd0;
      acc        <= 64'd0;
      bit_length <= 64'd0;
      rnd        <= 7'd0;
      eidx       <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= InitH[i];
      end
    end else begin
      state <= state_next;
      if (feed) begin
        fill <= fill + 7'(feed_cnt);
        acc  <= tot[3] ? combined[63:0] : combined[127:64];
        if (state == S_IDLE) begin
          bit_length <= bit_length + {57'd0, feed_cnt, 3'b000};
        end
      end
      if (blk_done) begin
        ret <= after;
        rnd <= 7'd0;
      end
      if (state == S_COMP) begin
        rnd <= rnd + 7'd1;
      end
      if (state == S_FIN) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
      if (emit_take) begin
        eidx <= eidx + 3'd1;
        if (eidx == 3'd7) begin
          bit_length <= 64'd0;
          fill       <= 7'd0;
          for (int i = 0; i < 8; i++) begin
            hash[i] <= InitH[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_word) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= combined[127:64];
    end else if (state == S_COMP) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
    end
    if (blk_done) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end else if (state == S_COMP) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sha512_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Hashes a stream of big-endian message words and returns the digest.
// ----------------------------------------------------------------------------
// Words enter the packer one by one; each full 128-byte block then holds the
// packer for the one-round-per-cycle compression loop. A last word adds
// padding plus one or two compressions, then eight digest words follow at
// one per cycle while pop is held. A two-entry queue accepts words meanwhile
// until it is full. Synchronous reset empties the queue and restores the
// initial hash values; the block is ready on the cycle after reset.
module sha512_stream_hasher (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  sha512_pkg::in_item_t  item,
  output logic                  full,
  output logic                  empty,
  output sha512_pkg::out_item_t result,
  input  wire                   pop
);
  import sha512_pkg::*;

  logic     q_valid;
  logic     q_take;
  in_item_t q_item;

  sha512_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  sha512_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .empty   (empty),
    .result  (result),
    .pop     (pop)
  );

endmodule
`default_nettype wire

### rtl/core/sha512_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the ports of the hasher for digest order, stalls and reset behavior.
// ----------------------------------------------------------------------------
module sha512_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   empty,
  input wire                   pop,
  input sha512_pkg::out_item_t result
);
  import sha512_pkg::*;

  // A digest is shown as eight words in index order.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.digest_last) |=>
      (!empty && result.digest_index == $past(result.digest_index) + 3'd1))
    else $error("digest index did not advance");

  a_last_is_seven: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.digest_last == (result.digest_index == 3'd7)))
    else $error("digest_last does not match index seven");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled word changed");

endmodule

bind sha512_stream_hasher sha512_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
`default_nettype wire

### dv/tb_sha512_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Sends messages as big-endian words with random byte counts and random idle
// gaps, computes each digest with an independent SHA-512 model, and checks
// every digest word that the block returns, in order.
// ----------------------------------------------------------------------------
module tb_sha512_stream_hasher;
  import sha512_pkg::*;

  localparam logic [63:0] KTab [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] HInit [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam int RandWords = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_item_t item = '0;
  logic full;
  logic empty;
  out_item_t result;
  logic pop = 1'b0;

  in_item_t pending_words[$];
  out_item_t digest_queue[$];
  logic [63:0] chain[8];
  logic [63:0] blk[16];
  logic [63:0] msg_bits;
  int unsigned fill;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_off = 0;
  bit feeding_done = 1'b0;

  sha512_stream_hasher dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .empty(empty), .result(result), .pop(pop)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] rr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w[80];
    logic [63:0] v[8];
    logic [63:0] t1;
    logic [63:0] t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 80; t++) begin
      w[t] = w[t-16] + w[t-7]
           + (rr(w[t-15], 1) ^ rr(w[t-15], 8) ^ (w[t-15] >> 7))
           + (rr(w[t-2], 19) ^ rr(w[t-2], 61) ^ (w[t-2] >> 6));
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + w[t];
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    if (fill % 8 == 0) blk[fill / 8] = '0;
    blk[fill / 8] |= {56'd0, b} << ((7 - fill % 8) * 8);
    fill++;
    if (fill == 128) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic hash_word(input in_item_t w);
    int unsigned n;
    out_item_t d;
    n = (w.byte_count > MaxBytes) ? 8 : w.byte_count;
    for (int i = 0; i < n; i++) begin
      absorb_byte(w.data_word[63 - 8*i -: 8]);
      msg_bits += 64'd8;
    end
    if (w.last_word) begin
      absorb_byte(8'h80);
      while (fill != 112) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(msg_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = chain[i];
        d.digest_index = i[2:0];
        d.digest_last = (i == 7);
        digest_queue.push_back(d);
      end
      for (int i = 0; i < 8; i++) chain[i] = HInit[i];
      msg_bits = '0;
      fill = 0;
    end
  endtask

  task automatic add_word(input logic [63:0] data, input int unsigned cnt, input bit lst);
    in_item_t w;
    w.data_word = data;
    w.byte_count = cnt[3:0];
    w.last_word = lst;
    pending_words.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !full) begin
      hash_word(item);
      words_sent++;
      send_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      if (send_wait == 0 && pending_words.size() > 0) begin
        item <= pending_words.pop_front();
      end else begin
        push <= 1'b0;
      end
    end else if (!push) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending_words.size() > 0) begin
        item <= pending_words.pop_front();
        push <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && hold_off > 0) hold_off--;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        digests_seen++;
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected word", result.digest_word, '0);
        end else begin
          if (result.digest_word !== digest_queue[0].digest_word)
            report_mismatch("digest_word", result.digest_word, digest_queue[0].digest_word);
          if (result.digest_index !== digest_queue[0].digest_index)
            report_mismatch("digest_index", result.digest_index,
                            digest_queue[0].digest_index);
          if (result.digest_last !== digest_queue[0].digest_last)
            report_mismatch("digest_last", result.digest_last, digest_queue[0].digest_last);
          void'(digest_queue.pop_front());
        end
        recv_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      if (hold_off > 0) begin
        pop <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned budget;
    int unsigned len;
    for (int i = 0; i < 8; i++) chain[i] = HInit[i];
    msg_bits = '0;
    fill = 0;
    add_word('0, 0, 1'b1);
    add_word(64'h6162_6300_0000_0000, 3, 1'b1);
    add_word('1, 8, 1'b0);
    add_word('0, 8, 1'b0);
    add_word(64'h0123_4567_89ab_cdef, 0, 1'b0);
    add_word(64'hfedc_ba98_7654_3210, 15, 1'b0);
    add_word('1, 9, 1'b1);
    for (int i = 0; i < 14; i++) add_word({$urandom, $urandom}, 8, 1'b0);
    add_word({$urandom, $urandom}, 7, 1'b1);
    for (int i = 0; i < 15; i++) add_word({$urandom, $urandom}, 8, 1'b0);
    add_word({$urandom, $urandom}, 8, 1'b1);
    budget = RandWords;
    while (budget > 0) begin
      len = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
      if (len > budget) len = budget;
      budget -= len;
      for (int i = 0; i < len; i++) begin
        add_word({$urandom, $urandom},
                 $urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : 8,
                 i == len - 1);
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Stall the output long enough for the input side to back up.
    repeat (60) @(posedge clk);
    hold_off = 3000;
    wait (pending_words.size() == 0 && !push);
    wait (digest_queue.size() == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d words across random message lengths and byte counts.", words_sent);
    $display("Checked %0d digest words, including empty and multi-block messages.",
             digests_seen);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
